// ----- hw/rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    // Heap geometry in 16-byte granules
    localparam int HEAP_GRANULES   = 65536;
    localparam int CHUNK_GRANULES  = 16384;
    localparam int HDR_GRANULES    = 2;

    localparam int GA_W     = $clog2(HEAP_GRANULES);   // header index bits
    localparam int BRK_W    = GA_W + 1;                // break holds the heap size
    localparam int BSZ_W    = 16;                      // stored payload granules
    localparam int WANT_W   = 21;                      // rounded request in granules
    localparam int GROW_W   = WANT_W + 2;              // growth arithmetic
    localparam int CHUNK_SH = $clog2(CHUNK_GRANULES);
    localparam int ENT_W    = BSZ_W + 1;               // {free, size}

    // Field widths
    localparam int OP_W    = 2;
    localparam int SIZE_W  = 24;
    localparam int ADDR_W  = 20;
    localparam int STAT_W  = 2;
    localparam int LIMIT_W = 21;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESIZE  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_ADDR = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_OOM  = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd1048576;

    // One header entry as kept in memory
    typedef struct packed {
        logic             free;
        logic [BSZ_W-1:0] size;
    } t_entry;

endpackage

// ----- hw/rtl/ffha_ifs.sv -----
// ----------------------------------------------------------------------------
// ffha_ifs
// Valid/ready channels of the allocator: request, response, configuration.
// ----------------------------------------------------------------------------
interface ffha_req_if import ffha_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] address;

    modport source (output valid, operation, size_bytes, address, input ready);
    modport sink   (input valid, operation, size_bytes, address, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_address;
    logic [ADDR_W-1:0] copy_source;
    logic [ADDR_W-1:0] copy_bytes;
    logic [STAT_W-1:0] status;

    modport source (output valid, result_address, copy_source, copy_bytes, status,
                    input ready);
    modport sink   (input valid, result_address, copy_source, copy_bytes, status,
                    output ready);
endinterface

interface ffha_cfg_if import ffha_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] heap_limit_bytes;

    modport source (output valid, heap_limit_bytes, input ready);
    modport sink   (input valid, heap_limit_bytes, output ready);
endinterface

// ----- hw/rtl/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/first_fit_heap_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator with split, chunked growth, coalescing and resize.
// ----------------------------------------------------------------------------
// One transaction at a time. Block headers sit in one 65536-entry memory with
// a registered read; every walk step is a read state followed by a decide
// state. A release is a chain lookup followed by a coalescing sweep, and a
// moving resize runs the lookup, the allocate and the release in turn before
// the response is handed over. No clearing pass is needed after reset.
module first_fit_heap_allocator_core
    import ffha_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ffha_req_if.sink      i_req,
    ffha_rsp_if.source    o_rsp,
    ffha_cfg_if.sink      i_cfg
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_A_RD   = 16'h0002,
        S_A_CHK  = 16'h0004,
        S_GROW   = 16'h0008,
        S_CARVE1 = 16'h0010,
        S_CARVE2 = 16'h0020,
        S_L_RD   = 16'h0040,
        S_L_CHK  = 16'h0080,
        S_RZ_EV  = 16'h0100,
        S_RZ_NX  = 16'h0200,
        S_REL    = 16'h0400,
        S_M_RD   = 16'h0800,
        S_M_CHK  = 16'h1000,
        S_M_NRD  = 16'h2000,
        S_M_NCHK = 16'h4000,
        S_OUT    = 16'h8000
    } t_state;

    t_state              r_state, n_state;
    logic [LIMIT_W-1:0]  r_limit;
    logic [BRK_W-1:0]    r_brk, n_brk;
    logic [BRK_W-1:0]    r_cur, n_cur;
    logic [BRK_W-1:0]    r_nxt, n_nxt;
    logic [WANT_W-1:0]   r_want, n_want;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [GA_W-1:0]     r_h, n_h;       // block being carved
    logic [GA_W-1:0]     r_oh, n_oh;     // block named by the request
    logic [BSZ_W-1:0]    r_hs, n_hs;     // size of the named block
    logic                r_hf, n_hf;
    logic [BSZ_W-1:0]    r_bsz, n_bsz;   // size of the block being carved
    logic [BSZ_W-1:0]    r_ms, n_ms;     // running size during coalescing
    logic                r_lrel, n_lrel; // lookup is for a release
    logic                r_move, n_move; // resize falls back to allocate
    logic [ADDR_W-1:0]   r_res, n_res;
    logic [ADDR_W-1:0]   r_src, n_src;
    logic [ADDR_W-1:0]   r_bytes, n_bytes;
    logic [STAT_W-1:0]   r_status, n_status;

    logic                w_we;
    logic [GA_W-1:0]     w_waddr, w_raddr;
    t_entry              w_wdata, w_rd;
    logic [ENT_W-1:0]    w_rdata;

    logic [BRK_W-1:0]    w_follow;
    logic [BSZ_W-1:0]    w_rest;
    logic                w_split;
    logic [GROW_W-1:0]   w_need, w_chunk, w_nb;
    logic [GA_W-1:0]     w_g;
    logic [BRK_W-1:0]    w_rz_n;
    logic [BRK_W-1:0]    w_sum_hn;
    logic                w_accept;

    ffha_ram #(.WIDTH(ENT_W), .DEPTH(HEAP_GRANULES)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd = t_entry'(w_rdata);

    // Shared datapath terms
    assign w_follow = r_cur + BRK_W'(HDR_GRANULES) + BRK_W'(w_rd.size);
    assign w_rest   = r_bsz - r_want[BSZ_W-1:0];
    assign w_split  = w_rest > BSZ_W'(HDR_GRANULES + 1);
    assign w_need   = GROW_W'(r_want) + GROW_W'(HDR_GRANULES);
    assign w_chunk  = ((w_need + GROW_W'(CHUNK_GRANULES - 1)) >> CHUNK_SH) << CHUNK_SH;
    assign w_nb     = GROW_W'(r_brk) + w_chunk;
    assign w_g      = i_req.address[ADDR_W-1:4];
    assign w_rz_n   = BRK_W'(r_oh) + BRK_W'(HDR_GRANULES) + BRK_W'(r_hs);
    assign w_sum_hn = BRK_W'(r_hs) + BRK_W'(HDR_GRANULES) + BRK_W'(w_rd.size);
    assign w_accept = i_req.valid && i_req.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid          = (r_state == S_OUT);
    assign o_rsp.result_address = r_res;
    assign o_rsp.copy_source    = r_src;
    assign o_rsp.copy_bytes     = r_bytes;
    assign o_rsp.status         = r_status;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_brk    = r_brk;
        n_cur    = r_cur;
        n_nxt    = r_nxt;
        n_want   = r_want;
        n_addr   = r_addr;
        n_h      = r_h;
        n_oh     = r_oh;
        n_hs     = r_hs;
        n_hf     = r_hf;
        n_bsz    = r_bsz;
        n_ms     = r_ms;
        n_lrel   = r_lrel;
        n_move   = r_move;
        n_res    = r_res;
        n_src    = r_src;
        n_bytes  = r_bytes;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_h;
        w_wdata  = '{free: 1'b0, size: r_bsz};
        w_raddr  = r_cur[GA_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                n_addr  = i_req.address;
                n_want  = WANT_W'((25'(i_req.size_bytes) + 25'd15) >> 4);
                n_oh    = w_g - GA_W'(HDR_GRANULES);
                n_cur   = '0;
                n_res   = '0;
                n_src   = '0;
                n_bytes = '0;
                n_move  = 1'b0;
                n_lrel  = 1'b1;
                if (w_accept) begin
                    n_state  = S_OUT;
                    n_status = ST_NONE;
                    case (i_req.operation)
                        OP_ALLOC: begin
                            if (i_req.size_bytes != '0) n_state = S_A_RD;
                        end
                        OP_RELEASE: begin
                            if (i_req.address[3:0] == 4'd0 && w_g >= GA_W'(HDR_GRANULES) &&
                                BRK_W'(w_g - GA_W'(HDR_GRANULES)) < r_brk) begin
                                n_state = S_L_RD;
                            end
                        end
                        OP_RESIZE: begin
                            if (i_req.address == '0) begin
                                if (i_req.size_bytes != '0) n_state = S_A_RD;
                            end else begin
                                n_lrel = (i_req.size_bytes == '0);
                                if (i_req.address[3:0] == 4'd0 &&
                                    w_g >= GA_W'(HDR_GRANULES) &&
                                    BRK_W'(w_g - GA_W'(HDR_GRANULES)) < r_brk) begin
                                    n_state = S_L_RD;
                                end else if (i_req.size_bytes != '0) begin
                                    n_status = ST_OOM;
                                end
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end

            // First-fit walk
            S_A_RD: begin
                n_state = (r_cur >= r_brk) ? S_GROW : S_A_CHK;
            end
            S_A_CHK: begin
                if (w_rd.free && WANT_W'(w_rd.size) >= r_want) begin
                    n_h     = r_cur[GA_W-1:0];
                    n_bsz   = w_rd.size;
                    n_hf    = 1'b0;
                    n_state = S_CARVE1;
                end else begin
                    n_cur   = w_follow;
                    n_state = S_A_RD;
                end
            end
            S_GROW: begin
                if (w_nb > GROW_W'(HEAP_GRANULES) || w_nb > GROW_W'(r_limit >> 4)) begin
                    n_status = ST_OOM;
                    n_state  = S_OUT;
                end else begin
                    n_h     = r_brk[GA_W-1:0];
                    n_bsz   = BSZ_W'(w_chunk - GROW_W'(HDR_GRANULES));
                    n_hf    = 1'b0;
                    n_brk   = w_nb[BRK_W-1:0];
                    n_state = S_CARVE1;
                end
            end

            // Split off the leftover, then write the taken header
            S_CARVE1: begin
                w_waddr = r_h + GA_W'(HDR_GRANULES) + r_want[GA_W-1:0];
                w_wdata = '{free: 1'b1, size: w_rest - BSZ_W'(HDR_GRANULES)};
                w_we    = w_split;
                n_state = S_CARVE2;
            end
            S_CARVE2: begin
                w_waddr  = r_h;
                w_wdata  = '{free: r_hf, size: w_split ? r_want[BSZ_W-1:0] : r_bsz};
                w_we     = 1'b1;
                n_res    = {r_h + GA_W'(HDR_GRANULES), 4'd0};
                n_status = ST_ADDR;
                n_state  = S_OUT;
                if (r_move) begin
                    n_src   = r_addr;
                    n_bytes = {r_hs, 4'd0};
                    n_state = S_REL;
                end
            end

            // Chain lookup of the named block
            S_L_RD: begin
                if (r_cur >= r_brk) begin
                    n_status = r_lrel ? ST_NONE : ST_OOM;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_L_CHK;
                end
            end
            S_L_CHK: begin
                if (r_cur == BRK_W'(r_oh)) begin
                    n_hs    = w_rd.size;
                    n_hf    = w_rd.free;
                    n_state = r_lrel ? S_REL : S_RZ_EV;
                end else begin
                    n_cur   = w_follow;
                    n_state = S_L_RD;
                end
            end

            // Resize: keep, grow into the successor, or move
            S_RZ_EV: begin
                w_raddr = w_rz_n[GA_W-1:0];
                if (WANT_W'(r_hs) >= r_want) begin
                    n_res    = r_addr;
                    n_status = ST_ADDR;
                    n_state  = S_OUT;
                end else if (w_rz_n < r_brk) begin
                    n_state = S_RZ_NX;
                end else begin
                    n_move  = 1'b1;
                    n_cur   = '0;
                    n_state = S_A_RD;
                end
            end
            S_RZ_NX: begin
                if (w_rd.free && WANT_W'(w_sum_hn) >= r_want) begin
                    n_h     = r_oh;
                    n_bsz   = w_sum_hn[BSZ_W-1:0];
                    n_state = S_CARVE1;
                end else begin
                    n_move  = 1'b1;
                    n_cur   = '0;
                    n_state = S_A_RD;
                end
            end

            // Mark free, then sweep and coalesce
            S_REL: begin
                w_waddr  = r_oh;
                w_wdata  = '{free: 1'b1, size: r_hs};
                w_we     = 1'b1;
                n_cur    = '0;
                n_state  = S_M_RD;
            end
            S_M_RD: begin
                n_state = (r_cur >= r_brk) ? S_OUT : S_M_CHK;
            end
            S_M_CHK: begin
                n_ms = w_rd.size;
                if (w_rd.free) begin
                    n_state = S_M_NRD;
                end else begin
                    n_cur   = w_follow;
                    n_state = S_M_RD;
                end
            end
            S_M_NRD: begin
                n_nxt   = r_cur + BRK_W'(HDR_GRANULES) + BRK_W'(r_ms);
                w_raddr = n_nxt[GA_W-1:0];
                if (n_nxt >= r_brk) begin
                    n_cur   = n_nxt;
                    n_state = S_M_RD;
                end else begin
                    n_state = S_M_NCHK;
                end
            end
            S_M_NCHK: begin
                if (w_rd.free) begin
                    n_ms    = r_ms + BSZ_W'(HDR_GRANULES) + w_rd.size;
                    w_waddr = r_cur[GA_W-1:0];
                    w_wdata = '{free: 1'b1, size: n_ms};
                    w_we    = 1'b1;
                    n_state = S_M_NRD;
                end else begin
                    n_cur   = r_nxt;
                    n_state = S_M_RD;
                end
            end

            S_OUT: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_brk   <= '0;
            r_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_brk   <= n_brk;
            if (i_cfg.valid && i_cfg.ready) r_limit <= i_cfg.heap_limit_bytes;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_nxt    <= n_nxt;
        r_want   <= n_want;
        r_addr   <= n_addr;
        r_h      <= n_h;
        r_oh     <= n_oh;
        r_hs     <= n_hs;
        r_hf     <= n_hf;
        r_bsz    <= n_bsz;
        r_ms     <= n_ms;
        r_lrel   <= n_lrel;
        r_move   <= n_move;
        r_res    <= n_res;
        r_src    <= n_src;
        r_bytes  <= n_bytes;
        r_status <= n_status;
    end

    // Checks
    a_brk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brk <= BRK_W'(HEAP_GRANULES))
        else $error("heap break beyond heap size");

    a_brk_grow_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_GROW) |=> $stable(r_brk))
        else $error("heap break moved outside growth");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CARVE1 || r_state == S_CARVE2 || r_state == S_REL ||
                  r_state == S_M_NCHK))
        else $error("header write in a non-writing state");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_ADDR) |-> (o_rsp.result_address == '0))
        else $error("address given with a failing status");

    a_copy_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.copy_bytes != '0) |-> (r_move && o_rsp.status == ST_ADDR))
        else $error("copy reported without a move");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit heap allocator core. A directed table
// covers the corner cases, then random allocate, release and resize traffic is
// checked against a heap model kept here. The run goes through several limit
// settings and sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;
    import ffha_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 96;
    localparam int DIR_ROWS       = 20;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [ADDR_W-1:0] copy_source;
        logic [ADDR_W-1:0] copy_bytes;
        logic [STAT_W-1:0] status;
    } t_alloc_rsp;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] address;
        logic              typed;
        t_alloc_rsp        rsp;
    } t_heap_row;

    logic i_clk;
    logic i_rst_n;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();
    ffha_cfg_if cfg_ch ();

    first_fit_heap_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Heap model state
    int unsigned       hdr_size [HEAP_GRANULES];
    bit                hdr_free [HEAP_GRANULES];
    int unsigned       heap_brk;
    longint unsigned   limit_bytes;

    t_alloc_rsp        pending_rsp [$];
    logic [ADDR_W-1:0] live_addr [$];
    int                mismatch_count;
    int                send_idle_pct;
    int                recv_stall_pct;
    logic              hold_go;
    logic              hold_active;
    int                quiet_cycles;
    t_heap_row         dir_tab [DIR_ROWS];

    // ------------------------------------------------------------------
    // Heap model
    // ------------------------------------------------------------------
    function automatic int unsigned next_hdr(int unsigned h);
        return h + HDR_GRANULES + hdr_size[h];
    endfunction

    function automatic bit on_chain(int unsigned h);
        int unsigned c;
        c = 0;
        while (c < heap_brk) begin
            if (c == h) return 1'b1;
            c = next_hdr(c);
        end
        return 1'b0;
    endfunction

    function automatic bit find_hdr(longint unsigned a, output int unsigned h);
        longint unsigned g;
        h = 0;
        if (a[3:0] != 4'd0) return 1'b0;
        g = a >> 4;
        if (g < HDR_GRANULES) return 1'b0;
        g = g - HDR_GRANULES;
        if (g >= heap_brk) return 1'b0;
        if (!on_chain(int'(g))) return 1'b0;
        h = int'(g);
        return 1'b1;
    endfunction

    function automatic void split_block(int unsigned h, int unsigned want);
        int unsigned rest;
        int unsigned nh;
        rest = hdr_size[h] - want;
        if (rest <= HDR_GRANULES + 1) return;
        nh = h + HDR_GRANULES + want;
        hdr_size[nh] = rest - HDR_GRANULES;
        hdr_free[nh] = 1'b1;
        hdr_size[h]  = want;
    endfunction

    function automatic void coalesce();
        int unsigned c;
        int unsigned n;
        c = 0;
        while (c < heap_brk) begin
            if (hdr_free[c]) begin
                n = next_hdr(c);
                while (n < heap_brk && hdr_free[n]) begin
                    hdr_size[c] += HDR_GRANULES + hdr_size[n];
                    n = next_hdr(c);
                end
            end
            c = next_hdr(c);
        end
    endfunction

    function automatic logic [STAT_W-1:0] heap_alloc(longint unsigned sz,
                                                     output logic [ADDR_W-1:0] pay);
        longint unsigned want, need, chunk, nb;
        int unsigned c;
        int unsigned h;
        pay = '0;
        if (sz == 0) return ST_NONE;
        want = (sz + 15) >> 4;
        // first fit along the chain
        c = 0;
        while (c < heap_brk) begin
            if (hdr_free[c] && hdr_size[c] >= want) begin
                split_block(c, int'(want));
                hdr_free[c] = 1'b0;
                pay = ADDR_W'((c + HDR_GRANULES) * 16);
                return ST_ADDR;
            end
            c = next_hdr(c);
        end
        // grow the break by whole chunks
        need  = HDR_GRANULES + want;
        chunk = ((need + CHUNK_GRANULES - 1) / CHUNK_GRANULES) * CHUNK_GRANULES;
        nb    = heap_brk + chunk;
        if (nb > HEAP_GRANULES || nb * 16 > limit_bytes) return ST_OOM;
        h = heap_brk;
        hdr_size[h] = int'(chunk - HDR_GRANULES);
        hdr_free[h] = 1'b1;
        heap_brk    = int'(nb);
        split_block(h, int'(want));
        hdr_free[h] = 1'b0;
        pay = ADDR_W'((h + HDR_GRANULES) * 16);
        return ST_ADDR;
    endfunction

    function automatic void heap_release(longint unsigned a);
        int unsigned h;
        if (a == 0 || !find_hdr(a, h)) return;
        hdr_free[h] = 1'b1;
        coalesce();
    endfunction

    function automatic t_alloc_rsp predict_rsp(logic [OP_W-1:0] op,
                                              logic [SIZE_W-1:0] sz,
                                              logic [ADDR_W-1:0] a);
        t_alloc_rsp r;
        int unsigned h;
        int unsigned n;
        longint unsigned want;
        int unsigned old_bytes;
        r = '0;
        r.status = ST_NONE;
        case (op)
            OP_ALLOC: r.status = heap_alloc(sz, r.result_address);
            OP_RELEASE: heap_release(a);
            OP_RESIZE: begin
                if (a == 0) begin
                    r.status = heap_alloc(sz, r.result_address);
                end else if (sz == 0) begin
                    heap_release(a);
                end else if (!find_hdr(a, h)) begin
                    r.status = ST_OOM;
                end else begin
                    want = (longint'(sz) + 15) >> 4;
                    n = next_hdr(h);
                    if (hdr_size[h] >= want) begin
                        r.result_address = a;
                        r.status = ST_ADDR;
                    end else if (n < heap_brk && hdr_free[n] &&
                                 longint'(hdr_size[h]) + HDR_GRANULES + hdr_size[n] >= want) begin
                        hdr_size[h] += HDR_GRANULES + hdr_size[n];
                        split_block(h, int'(want));
                        r.result_address = a;
                        r.status = ST_ADDR;
                    end else begin
                        old_bytes = hdr_size[h] * 16;
                        r.status = heap_alloc(sz, r.result_address);
                        if (r.status == ST_ADDR) begin
                            r.copy_source = a;
                            r.copy_bytes  = ADDR_W'(old_bytes);
                            heap_release(a);
                        end
                    end
                end
            end
            default: ;
        endcase
        if (r.status != ST_ADDR) r.result_address = '0;
        return r;
    endfunction

    // Keep the list of live payload addresses in step with the model
    function automatic void drop_live(logic [ADDR_W-1:0] a);
        for (int i = live_addr.size() - 1; i >= 0; i--)
            if (live_addr[i] == a) live_addr.delete(i);
    endfunction

    function automatic void track_live(logic [OP_W-1:0] op, logic [SIZE_W-1:0] sz,
                                       logic [ADDR_W-1:0] a, t_alloc_rsp r);
        if (op == OP_RELEASE || (op == OP_RESIZE && sz == 0 && a != 0)) drop_live(a);
        if (r.copy_source != 0) drop_live(r.copy_source);
        if (r.status == ST_ADDR) begin
            drop_live(r.result_address);
            live_addr.push_back(r.result_address);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Response side: stall at random, hold off on request, check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rsp_ch.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        hold_active <= 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_active <= 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_alloc_rsp got, want_rsp;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.result_address, rsp_ch.copy_source,
                    rsp_ch.copy_bytes, rsp_ch.status};
            if (pending_rsp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response: addr %0d src %0d bytes %0d status %0d",
                             got.result_address, got.copy_source, got.copy_bytes,
                             got.status);
            end else begin
                want_rsp = pending_rsp.pop_front();
                if (got !== want_rsp) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected addr %0d src %0d bytes %0d status %0d,",
                                  " got addr %0d src %0d bytes %0d status %0d"},
                                 want_rsp.result_address, want_rsp.copy_source,
                                 want_rsp.copy_bytes, want_rsp.status,
                                 got.result_address, got.copy_source,
                                 got.copy_bytes, got.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_op(logic [OP_W-1:0] op, logic [SIZE_W-1:0] sz,
                           logic [ADDR_W-1:0] a, logic typed, t_alloc_rsp typed_rsp);
        t_alloc_rsp r;
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.size_bytes <= sz;
        req_ch.address    <= a;
        do @(posedge i_clk); while (!req_ch.ready);
        // transaction accepted: advance the model
        r = predict_rsp(op, sz, a);
        track_live(op, sz, a, r);
        pending_rsp.push_back(typed ? typed_rsp : r);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.heap_limit_bytes <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        limit_bytes = v;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int p;
        p = $urandom_range(99);
        if (p < 70) return SIZE_W'($urandom_range(1, 512));
        if (p < 90) return SIZE_W'($urandom_range(1, 8192));
        if (p < 97) return SIZE_W'($urandom_range(8193, 300000));
        return SIZE_W'($urandom);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_live();
        if (live_addr.size() == 0) return ADDR_W'($urandom);
        return live_addr[$urandom_range(live_addr.size() - 1)];
    endfunction

    task automatic run_random(int count);
        int p;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(99);
            if (live_addr.size() > 40 && p < 45) p = 50;
            if (p < 45)
                send_op(OP_ALLOC, pick_size(), ADDR_W'($urandom), 1'b0, '0);
            else if (p < 72)
                send_op(OP_RELEASE, SIZE_W'($urandom), pick_live(), 1'b0, '0);
            else if (p < 92)
                send_op(OP_RESIZE, ($urandom_range(9) == 0) ? '0 : pick_size(),
                        ($urandom_range(9) == 0) ? '0 : pick_live(), 1'b0, '0);
            else begin
                // noise: stray addresses and the unused code
                case ($urandom_range(2))
                    0: send_op(OP_UNUSED, SIZE_W'($urandom), ADDR_W'($urandom), 1'b0, '0);
                    1: send_op(OP_RELEASE, '0, ADDR_W'($urandom), 1'b0, '0);
                    default: send_op(OP_RESIZE, pick_size(), ADDR_W'($urandom), 1'b0, '0);
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_alloc_rsp none_rsp, oom_rsp;
        none_rsp = '{'0, '0, '0, ST_NONE};
        oom_rsp  = '{'0, '0, '0, ST_OOM};
        dir_tab = '{
            '{OP_ALLOC,   24'd0,        20'd0,       1'b1, none_rsp},
            '{OP_RELEASE, 24'd0,        20'd0,       1'b1, none_rsp},
            '{OP_UNUSED,  24'hFFFFFF,   20'hFFFFF,   1'b1, none_rsp},
            '{OP_ALLOC,   24'd1,        20'd0,       1'b1, '{20'd32, '0, '0, ST_ADDR}},
            '{OP_ALLOC,   24'hFFFFFF,   20'd0,       1'b1, oom_rsp},
            '{OP_RELEASE, 24'd0,        20'd17,      1'b1, none_rsp},
            '{OP_RESIZE,  24'd5,        20'hFFFF0,   1'b1, oom_rsp},
            '{OP_RESIZE,  24'd0,        20'd0,       1'b1, none_rsp},
            '{OP_ALLOC,   24'd100,      20'd0,       1'b0, '0},
            '{OP_ALLOC,   24'd16,       20'd0,       1'b0, '0},
            '{OP_RESIZE,  24'd16,       20'd32,      1'b1, '{20'd32, '0, '0, ST_ADDR}},
            '{OP_RESIZE,  24'd48,       20'd32,      1'b0, '0},
            '{OP_RELEASE, 24'd0,        20'd32,      1'b1, none_rsp},
            '{OP_RELEASE, 24'd0,        20'd32,      1'b1, none_rsp},
            '{OP_RESIZE,  24'd0,        20'd80,      1'b1, none_rsp},
            '{OP_ALLOC,   24'd300000,   20'd0,       1'b0, '0},
            '{OP_RESIZE,  24'd16,       20'd32,      1'b0, '0},
            '{OP_RELEASE, 24'd0,        20'd16,      1'b1, none_rsp},
            '{OP_ALLOC,   24'd1048575,  20'd0,       1'b0, '0},
            '{OP_RESIZE,  24'd200,      20'd0,       1'b0, '0}
        };

        // Reset values of the model and the inputs
        for (int g = 0; g < HEAP_GRANULES; g++) begin
            hdr_size[g] = 0;
            hdr_free[g] = 1'b0;
        end
        heap_brk       = 0;
        limit_bytes    = LIMIT_RESET;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1'b0;
        i_rst_n                 <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.operation        <= OP_ALLOC;
        req_ch.size_bytes       <= '0;
        req_ch.address          <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.heap_limit_bytes <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset limit
        for (int i = 0; i < DIR_ROWS; i++)
            send_op(dir_tab[i].operation, dir_tab[i].size_bytes, dir_tab[i].address,
                    dir_tab[i].typed, dir_tab[i].rsp);
        drain();

        // No idling, limit equal to the heap size
        write_limit(21'd1048576);
        run_random(PHASE_ITEMS);
        drain();

        // Sender mostly idle, limit above the heap size
        write_limit(21'h1FFFFF);
        send_idle_pct = 80;
        run_random(PHASE_ITEMS);
        drain();

        // Receiver mostly stalling, with a long hold-off while the sender waits
        write_limit(21'd262144);
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        hold_go        = 1'b1;
        run_random(PHASE_ITEMS);
        drain();

        // Both sides idling, zero limit
        write_limit(21'd0);
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        run_random(PHASE_ITEMS);
        drain();

        // Back to full speed with a middle limit
        write_limit(21'd524288);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        drain();

        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ifs.sv
hw/rtl/ffha_ram.sv
hw/rtl/first_fit_heap_allocator_core.sv
sim/testbench.sv
